@@ design/fys_pkg.sv @@
// Shared constants, types and helper functions of the Fisher-Yates shuffle engine.
package fys_pkg;

    localparam int MAX_SIZE_LOG = 10;
    localparam int IDX_W        = MAX_SIZE_LOG;
    localparam int DEPTH        = 1 << MAX_SIZE_LOG;
    localparam int MEM_W        = IDX_W + 1;
    localparam int LOG_W        = 4;
    localparam int WORD_W       = 32;
    localparam int DIV_CNT_W    = $clog2(WORD_W);

    localparam logic [LOG_W-1:0] SIZE_LOG2_RESET = LOG_W'(10);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD_I,
        S_RD_J,
        S_WR_J,
        S_WR_I,
        S_RD_L,
        S_WR_L,
        S_ONE
    } fys_state_t;

    // Sizes above the supported maximum are clamped.
    function automatic logic [LOG_W-1:0] fys_sat_log(input logic [LOG_W-1:0] lg);
        if (32'(lg) > MAX_SIZE_LOG)
            return LOG_W'(MAX_SIZE_LOG);
        return lg;
    endfunction

    // A stored word is live when its tag bit is set; otherwise the entry
    // still holds the identity, its own index.
    function automatic logic [IDX_W-1:0] fys_live(input logic [MEM_W-1:0] word,
                                                 input logic [IDX_W-1:0] addr);
        if (word[IDX_W])
            return word[IDX_W-1:0];
        return addr;
    endfunction

endpackage

@@ design/fys_if.sv @@
// Channel interfaces for random words in and permutation entries out.
interface fys_word_if
    import fys_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

interface fys_result_if
    import fys_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] entry_value;
    logic             last;

    modport source (output valid, output position, output entry_value, output last,
                    input ready);
    modport sink   (input valid, input position, input entry_value, input last,
                    output ready);
endinterface

@@ design/fys_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module fys_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/fys_divider.sv @@
// Bit-serial restoring divider that returns the remainder of a 32-bit word.
module fys_divider
    import fys_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [IDX_W:0]    divisor,
    output logic              done,
    output logic [IDX_W-1:0]  remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]    dvd_reg;
    logic [IDX_W:0]       rem_reg;
    logic [IDX_W:0]       dsr_reg;
    logic [IDX_W+1:0]     trial;
    logic [IDX_W+1:0]     diff;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The partial remainder stays below the divisor, so the shifted trial
    // value never needs more than one extra bit.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_reg <= diff[IDX_W:0];
            else
                rem_reg <= trial[IDX_W:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[IDX_W-1:0];

endmodule

@@ design/fisher_yates_shuffle.sv @@
// Top level of the Fisher-Yates shuffle engine: step sequencer, store and result register.
//
//  Channel   | Direction | Payload                          | Handshake
//  ----------+-----------+----------------------------------+--------------------
//  words     | sink      | random_word[31:0]                | valid / ready
//  results   | source    | position, entry_value, last      | valid / ready
//  cfg       | write     | cfg_wdata[3:0] = size_log2       | cfg_wen, no wait
//
// Each item is accepted, reduced to a remainder by 32 iterations of the serial divider and
// then takes two reads and two writes on the one-read, one-write permutation RAM. The
// final step of a run adds one more read and one more write for the last entry; an item
// at size one only hands out its single entry.
// After reset a clearing pass walks all 1024 RAM entries; no word is taken meanwhile.
// A waiting result sits in an output register; the sequencer stalls in each state that
// emits a result whenever that register still holds a transaction that has not been taken.
module fisher_yates_shuffle
    import fys_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    fys_word_if.sink           words,
    fys_result_if.source       results,
    input  logic               cfg_wen,
    input  logic [LOG_W-1:0]   cfg_wdata
);

    fys_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [LOG_W-1:0]   size_log2_reg;
    logic [LOG_W-1:0]   run_log_reg, run_log_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   vi_reg, vi_next;
    logic [IDX_W-1:0]   vj_reg, vj_next;

    logic               res_valid_reg;
    logic [IDX_W-1:0]   res_pos_reg;
    logic [IDX_W-1:0]   res_val_reg;
    logic               res_last_reg;

    logic               emit;
    logic [IDX_W-1:0]   emit_pos;
    logic [IDX_W-1:0]   emit_val;
    logic               emit_last;
    logic               slot_free;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [MEM_W-1:0]   mem_rdata;

    logic               div_start;
    logic [IDX_W:0]     div_divisor;
    logic               div_done;
    logic [IDX_W-1:0]   div_rem;

    logic [LOG_W-1:0]   log_sel;
    logic [IDX_W:0]     n_sel;
    logic [IDX_W:0]     n_sel_m2;
    logic [IDX_W:0]     i_sel;
    logic [IDX_W:0]     n_cur;
    logic [IDX_W:0]     n_cur_m1;
    logic [IDX_W:0]     n_cur_m2;

    fys_ram #(
        .DATA_W (MEM_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fys_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (words.random_word),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // The size register is sampled only when a run begins.
    assign log_sel  = (step_reg == '0) ? fys_sat_log(size_log2_reg) : run_log_reg;
    assign n_sel    = (IDX_W+1)'(1) << log_sel;
    assign n_sel_m2 = n_sel - (IDX_W+1)'(2);
    assign i_sel    = ({1'b0, step_reg} > n_sel_m2) ? n_sel_m2 : {1'b0, step_reg};

    assign n_cur    = (IDX_W+1)'(1) << run_log_reg;
    assign n_cur_m1 = n_cur - (IDX_W+1)'(1);
    assign n_cur_m2 = n_cur - (IDX_W+1)'(2);

    assign slot_free   = !res_valid_reg || results.ready;
    assign words.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            size_log2_reg <= SIZE_LOG2_RESET;
            run_log_reg   <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            run_log_reg <= run_log_next;
            step_reg    <= step_next;
            if (cfg_wen)
            begin
                size_log2_reg <= cfg_wdata;
            end
            if (emit)
                res_valid_reg <= 1'b1;
            else if (results.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg  <= i_next;
        j_reg  <= j_next;
        vi_reg <= vi_next;
        vj_reg <= vj_next;
        if (emit)
        begin
            res_pos_reg  <= emit_pos;
            res_val_reg  <= emit_val;
            res_last_reg <= emit_last;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        run_log_next = run_log_reg;
        step_next    = step_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        vi_next      = vi_reg;
        vj_next      = vj_reg;
        emit         = 1'b0;
        emit_pos     = '0;
        emit_val     = '0;
        emit_last    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        div_start    = 1'b0;
        div_divisor  = n_sel - i_sel;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (words.valid)
                begin
                    run_log_next = log_sel;
                    if (n_sel == (IDX_W+1)'(1))
                    begin
                        step_next  = '0;
                        state_next = S_ONE;
                    end
                    else
                    begin
                        i_next     = i_sel[IDX_W-1:0];
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    j_next     = i_reg + div_rem;
                    state_next = S_RD_I;
                end
            end
            S_RD_I:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = S_RD_J;
            end
            S_RD_J:
            begin
                mem_re     = 1'b1;
                mem_raddr  = j_reg;
                vi_next    = fys_live(mem_rdata, i_reg);
                state_next = S_WR_J;
            end
            S_WR_J:
            begin
                vj_next = fys_live(mem_rdata, j_reg);
                if (j_reg != i_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = {1'b1, vi_reg};
                end
                state_next = S_WR_I;
            end
            S_WR_I:
            begin
                if (slot_free)
                begin
                    // Entry i is final: hand it out and return it to the identity.
                    mem_we    = 1'b1;
                    mem_waddr = i_reg;
                    emit      = 1'b1;
                    emit_pos  = i_reg;
                    emit_val  = vj_reg;
                    if (i_reg == n_cur_m2[IDX_W-1:0])
                    begin
                        step_next  = '0;
                        state_next = S_RD_L;
                    end
                    else
                    begin
                        step_next  = i_reg + IDX_W'(1);
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD_L:
            begin
                mem_re     = 1'b1;
                mem_raddr  = n_cur_m1[IDX_W-1:0];
                state_next = S_WR_L;
            end
            S_WR_L:
            begin
                if (slot_free)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = n_cur_m1[IDX_W-1:0];
                    emit       = 1'b1;
                    emit_pos   = n_cur_m1[IDX_W-1:0];
                    emit_val   = fys_live(mem_rdata, n_cur_m1[IDX_W-1:0]);
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ONE:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign results.valid       = res_valid_reg;
    assign results.position    = res_pos_reg;
    assign results.entry_value = res_val_reg;
    assign results.last        = res_last_reg;

endmodule

@@ design/fys_checker.sv @@
// Port-level checker for the Fisher-Yates shuffle engine and its bind to the top level.
module fys_checker
    import fys_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             words_valid,
    input logic             words_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic [IDX_W-1:0] res_position,
    input logic [IDX_W-1:0] res_entry_value,
    input logic             res_last
);

    logic [IDX_W-1:0] exp_pos_reg;

    // Positions of a run come out in order from zero; a new run starts after last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pos_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            exp_pos_reg <= res_last ? '0 : (res_position + IDX_W'(1));
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_position)
            && $stable(res_entry_value) && $stable(res_last))
        else $error("result changed while stalled");

    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |-> res_position == exp_pos_reg)
        else $error("result position out of order");

    a_size_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last && res_position == '0 |-> res_entry_value == '0)
        else $error("single-entry permutation must hold zero");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        words_valid && words_ready |=> !words_ready)
        else $error("second word taken while a step is in progress");

endmodule

bind fisher_yates_shuffle fys_checker u_fys_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .words_valid     (words.valid),
    .words_ready     (words.ready),
    .res_valid       (results.valid),
    .res_ready       (results.ready),
    .res_position    (results.position),
    .res_entry_value (results.entry_value),
    .res_last        (results.last)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the Fisher-Yates shuffle engine with a permutation scoreboard.
module tb;
    import fys_pkg::*;

    localparam int IDLE_PCT      = 31;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 20000;
    localparam int WORD_COUNT    = 1750;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 100;
    localparam int FULL_RUN      = DEPTH - 1;

    typedef struct packed {
        logic [IDX_W-1:0] position;
        logic [IDX_W-1:0] entry_value;
        logic             last;
    } perm_entry_t;

    class shuffle_scoreboard;
        logic [IDX_W-1:0] slot_value [DEPTH];
        bit               slot_live [DEPTH];
        logic [LOG_W-1:0] size_reg;
        int unsigned      run_log;
        int unsigned      step;
        perm_entry_t      expected_entries [$];
        int               errors;

        function new();
            size_reg = SIZE_LOG2_RESET;
            run_log  = 0;
            step     = 0;
            errors   = 0;
            foreach (slot_live[k])
            begin
                slot_live[k]  = 1'b0;
                slot_value[k] = '0;
            end
        endfunction

        function void set_size(logic [LOG_W-1:0] lg);
            size_reg = lg;
        endfunction

        // An entry that has not been swapped in this run still holds its own index.
        function logic [IDX_W-1:0] fetch(int unsigned k);
            return slot_live[k] ? slot_value[k] : IDX_W'(k);
        endfunction

        function void add_expected(logic [IDX_W-1:0] pos, logic [IDX_W-1:0] val,
                                   logic lst);
            perm_entry_t e;
            e.position    = pos;
            e.entry_value = val;
            e.last        = lst;
            expected_entries.insert(expected_entries.size(), e);
        endfunction

        function void note_word(logic [WORD_W-1:0] w);
            int unsigned      n;
            int unsigned      i;
            int unsigned      j;
            logic [IDX_W-1:0] vi;
            logic [IDX_W-1:0] vj;
            logic [IDX_W-1:0] vl;
            if (step == 0)
                run_log = (size_reg > MAX_SIZE_LOG) ? MAX_SIZE_LOG : size_reg;
            n = 1 << run_log;
            if (n == 1)
            begin
                step = 0;
                add_expected('0, '0, 1'b1);
                return;
            end
            i  = (step > n - 2) ? n - 2 : step;
            j  = i + w % (n - i);
            vi = fetch(i);
            vj = fetch(j);
            if (j != i)
            begin
                slot_value[j] = vi;
                slot_live[j]  = 1'b1;
            end
            slot_live[i] = 1'b0;
            add_expected(IDX_W'(i), vj, 1'b0);
            if (i == n - 2)
            begin
                vl = fetch(n - 1);
                slot_live[n - 1] = 1'b0;
                add_expected(IDX_W'(n - 1), vl, 1'b1);
                step = 0;
            end
            else
                step = i + 1;
        endfunction

        function void check_result(perm_entry_t got);
            perm_entry_t want;
            if (expected_entries.size() == 0)
            begin
                $error("unexpected result: position %0d, entry_value %0d, last %0d",
                       got.position, got.entry_value, got.last);
                errors++;
                return;
            end
            want = expected_entries.pop_front();
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.entry_value !== want.entry_value)
            begin
                $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wen;
    logic [LOG_W-1:0] cfg_wdata;

    fys_word_if   words ();
    fys_result_if results ();

    shuffle_scoreboard sb = new();

    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;

    fisher_yates_shuffle dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .words     (words),
        .results   (results),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && words.valid && words.ready)
            sb.note_word(words.random_word);
        if (rst_n && results.valid && results.ready)
        begin
            sb.check_result('{results.position, results.entry_value, results.last});
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        if ((words.valid && words.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random back-pressure, one long hold-off that fills the block, and a
    // calm window with ready held high.
    initial
    begin
        bit held;
        held = 1'b0;
        results.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 200)
            begin
                held = 1'b1;
                results.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            results.ready <= (results_seen >= 500 && results_seen < 800) ||
                             ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w);
        bit calm;
        calm = (words_sent >= 500 && words_sent < 800);
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                words.valid <= 1'b0;
                @(posedge clk);
            end
        words.valid       <= 1'b1;
        words.random_word <= w;
        do
            @(posedge clk);
        while (!words.ready);
        words_sent++;
    endtask

    // Hold the sender back until every outstanding transaction has come out.
    task automatic drain_results();
        words.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [LOG_W-1:0] lg);
        cfg_wen   <= 1'b1;
        cfg_wdata <= lg;
        @(posedge clk);
        sb.set_size(lg);
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'($urandom_range(0, 2047));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LOG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return LOG_W'(0);
            1:       return LOG_W'(1);
            9:       return LOG_W'($urandom_range(6, 8));
            default: return LOG_W'($urandom_range(2, 5));
        endcase
    endfunction

    initial
    begin
        int unsigned start;
        int unsigned phase;
        int unsigned count;
        rst_n             <= 1'b0;
        cfg_wen           <= 1'b0;
        cfg_wdata         <= '0;
        words.valid       <= 1'b0;
        words.random_word <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Size one: every word gives a single last entry.
        write_size(LOG_W'(0));
        send_word('0);
        send_word('1);
        drain_results();

        write_size(LOG_W'(1));
        send_word('0);
        send_word('1);
        drain_results();

        // Leave a run of four partly done, then shrink the size; the change must wait
        // for the next run.
        write_size(LOG_W'(2));
        send_word('1);
        send_word(32'h0000_0001);
        send_word(32'h8000_0000);
        send_word(32'h0000_0003);
        drain_results();
        write_size(LOG_W'(0));
        send_word(32'h7FFF_FFFF);
        send_word(32'h5555_5555);
        send_word(32'hAAAA_AAAA);
        drain_results();

        write_size(LOG_W'(3));
        for (int k = 0; k < 7; k++)
            send_word('1 >> (4 * k));
        drain_results();

        start = words_sent;
        phase = 0;
        while (words_sent - start < WORD_COUNT)
        begin
            drain_results();
            // The first phase runs one full permutation at an oversized setting.
            if (phase == 0)
            begin
                write_size('1);
                count = FULL_RUN;
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    write_size(pick_size());
                count = $urandom_range(4, 40);
            end
            repeat (count)
                send_word(pick_word());
            phase++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
design/fys_pkg.sv
design/fys_if.sv
design/fys_ram.sv
design/fys_divider.sv
design/fisher_yates_shuffle.sv
design/fys_checker.sv
tb/sv/tb.sv
